// File: rtl/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
// Used by tmcw_ctrl, tmcw_datapath and text_mode_console_writer_unit; no dependencies.
`default_nettype none

package tmcw_pkg;

    // Field widths fixed by the interface
    localparam int KIND_W = 1;
    localparam int CODE_W = 9;
    localparam int ADDR_W = 11;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

    // Special character codes
    localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
    localparam logic [CODE_W-1:0] CODE_LEFT      = 9'd228;
    localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;

    // Echo bytes
    localparam logic [BYTE_W-1:0] ECHO_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;

    // Configuration
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_ATTR = 1'b0;

    // Result index within a backspace item (single-result items use EMIT_FIRST)
    localparam logic [1:0] EMIT_FIRST = 2'd0;
    localparam logic [1:0] EMIT_SPACE = 2'd1;
    localparam logic [1:0] EMIT_FINAL = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       take;       // latch the offered item
        logic       exec;       // move the cursor, write the cell or issue the read
        logic       scan_run;   // step the sweep counter over the store
        logic       scan_copy;  // sweep moves rows up (else it clears)
        logic       load_out;   // load one result into the output register
        logic [1:0] emit_idx;   // which result of the item is loaded
    } tmcw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_read;      // latched item is a read
        logic multi;        // latched item is a backspace put
        logic need_scroll;  // cursor reaches the row past the screen
        logic scan_done;    // sweep writes its last cell this cycle
        logic out_free;     // output register can take a result
    } tmcw_status_t;

endpackage

`default_nettype wire

// File: rtl/text_mode_console_writer_unit.sv
// Text-mode console writer: top level with the attribute register and APB port.
// Depends on tmcw_pkg; instantiates tmcw_ctrl and tmcw_datapath.
//
// Use: items enter on in_valid/in_ready (kind, char_code, cell_address) and
// results leave on out_valid/out_ready (serial_valid, serial_byte, cursor_pos,
// cell_data, last). A put item moves the cursor and writes the screen store;
// a read item returns one cell. last marks the final result of an item.
// The block works on one item at a time: accept, execute, emit. A plain put,
// newline, left arrow or read emits one result; backspace emits three. A put
// that pushes the cursor past the last row scrolls the screen with one sweep
// over the store through its one read and one write port before its result.
// The result of an item sits in an output register, so the next item is
// accepted while it waits; a stalled receiver holds the block in its emit
// step whenever the output register still holds an earlier result.
// After reset the store is cleared by the same sweep, with in_ready low; the
// cursor is 0 and text_attribute is 7.
// text_attribute sits at byte address 0 of the APB port; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`default_nettype none

module text_mode_console_writer_unit #(
    parameter int COLUMNS   = 80,
    parameter int TEXT_ROWS = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tmcw_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tmcw_pkg::KIND_W-1:0]     kind,
    input  wire logic [tmcw_pkg::CODE_W-1:0]     char_code,
    input  wire logic [tmcw_pkg::ADDR_W-1:0]     cell_address,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 serial_valid,
    output logic [tmcw_pkg::BYTE_W-1:0]          serial_byte,
    output logic [tmcw_pkg::POS_W-1:0]           cursor_pos,
    output logic [tmcw_pkg::CELL_W-1:0]          cell_data,
    output logic                                 last
);

    // Attribute register on the APB port
    logic [tmcw_pkg::BYTE_W-1:0] attr_reg;
    logic                        attr_sel;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[2] == tmcw_pkg::REG_ATTR);
    assign prdata   = attr_sel ? 32'(attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tmcw_pkg::ATTR_RESET;
        end
        else if (psel && penable && pwrite && attr_sel)
        begin
            attr_reg <= pwdata[tmcw_pkg::BYTE_W-1:0];
        end
    end

    tmcw_pkg::tmcw_cmd_t    cmd;
    tmcw_pkg::tmcw_status_t status;

    tmcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tmcw_datapath #(
        .COLUMNS   (COLUMNS),
        .TEXT_ROWS (TEXT_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .attr         (attr_reg),
        .kind         (kind),
        .char_code    (char_code),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_valid (serial_valid),
        .serial_byte  (serial_byte),
        .cursor_pos   (cursor_pos),
        .cell_data    (cell_data),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: rtl/tmcw_ctrl.sv
// Controller state machine of the text-mode console writer.
// Depends on tmcw_pkg; drives tmcw_datapath through tmcw_cmd_t.
`default_nettype none

module tmcw_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  var  tmcw_pkg::tmcw_status_t status,
    output tmcw_pkg::tmcw_cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one item: accept, execute, optional scroll, emit results
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.emit_idx  = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    idx_next   = tmcw_pkg::EMIT_FIRST;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!status.is_read && status.need_scroll)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SCROLL:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_copy = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.multi && idx_reg != tmcw_pkg::EMIT_FINAL)
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold state; start with the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= tmcw_pkg::EMIT_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tmcw_datapath.sv
// Datapath of the text-mode console writer: item latch, cursor, screen memory,
// sweep counter and output register. Depends on tmcw_pkg; driven by tmcw_ctrl.
`default_nettype none

module tmcw_datapath #(
    parameter int COLUMNS   = 80,
    parameter int TEXT_ROWS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  var  tmcw_pkg::tmcw_cmd_t         cmd,
    output tmcw_pkg::tmcw_status_t           status,
    input  wire logic [tmcw_pkg::BYTE_W-1:0] attr,
    input  wire logic [tmcw_pkg::KIND_W-1:0] kind,
    input  wire logic [tmcw_pkg::CODE_W-1:0] char_code,
    input  wire logic [tmcw_pkg::ADDR_W-1:0] cell_address,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             serial_valid,
    output logic [tmcw_pkg::BYTE_W-1:0]      serial_byte,
    output logic [tmcw_pkg::POS_W-1:0]       cursor_pos,
    output logic [tmcw_pkg::CELL_W-1:0]      cell_data,
    output logic                             last
);

    localparam int VIS   = COLUMNS * TEXT_ROWS;
    localparam int MOVED = COLUMNS * (TEXT_ROWS - 1);
    localparam int AW    = $clog2(VIS);
    localparam int PW    = AW + 1;
    localparam int CNTW  = $clog2(VIS + 1);
    localparam int RW    = $clog2(TEXT_ROWS + 1);
    localparam int COLW  = $clog2(COLUMNS);

    // Item latch
    logic [tmcw_pkg::KIND_W-1:0] kind_reg;
    logic [tmcw_pkg::CODE_W-1:0] code_reg;
    logic [tmcw_pkg::ADDR_W-1:0] addr_reg;
    logic                        addr_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg    <= kind;
            code_reg    <= char_code;
            addr_reg    <= cell_address;
            addr_ok_reg <= (32'(cell_address) < VIS);
        end
    end

    logic is_nl, is_left, is_bs, is_read;
    assign is_nl   = (code_reg == tmcw_pkg::CODE_NEWLINE);
    assign is_left = (code_reg == tmcw_pkg::CODE_LEFT);
    assign is_bs   = (code_reg == tmcw_pkg::CODE_BACKSPACE);
    assign is_read = (kind_reg == tmcw_pkg::KIND_READ);

    // Cursor as linear position plus row and column
    logic [AW-1:0]   pos_reg;
    logic [RW-1:0]   row_reg;
    logic [COLW-1:0] col_reg;
    logic [PW-1:0]   pos_step;
    logic [RW-1:0]   row_step;
    logic [COLW-1:0] col_step;
    logic            scroll;

    always_comb
    begin
        pos_step = {1'b0, pos_reg};
        row_step = row_reg;
        col_step = col_reg;
        priority if (is_nl)
        begin
            pos_step = {1'b0, pos_reg} + PW'(COLUMNS) - PW'(col_reg);
            row_step = row_reg + RW'(1);
            col_step = '0;
        end
        else if (is_bs || is_left)
        begin
            if (pos_reg != '0)
            begin
                pos_step = {1'b0, pos_reg} - PW'(1);
                if (col_reg == '0)
                begin
                    col_step = COLW'(COLUMNS - 1);
                    row_step = row_reg - RW'(1);
                end
                else
                begin
                    col_step = col_reg - COLW'(1);
                end
            end
        end
        else
        begin
            pos_step = {1'b0, pos_reg} + PW'(1);
            if (col_reg == COLW'(COLUMNS - 1))
            begin
                col_step = '0;
                row_step = row_reg + RW'(1);
            end
            else
            begin
                col_step = col_reg + COLW'(1);
            end
        end
    end

    assign scroll = (row_step == RW'(TEXT_ROWS));

    // Advance the cursor; a scroll lands it at the start of the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.exec && !is_read)
        begin
            if (scroll)
            begin
                pos_reg <= AW'(MOVED);
                row_reg <= RW'(TEXT_ROWS - 1);
                col_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_step[AW-1:0];
                row_reg <= row_step;
                col_reg <= col_step;
            end
        end
    end

    // Sweep counter: read one row ahead, write the cell behind
    logic [CNTW-1:0] cnt_reg;
    logic            scan_done;
    assign scan_done = (cnt_reg == CNTW'(VIS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.scan_run)
        begin
            if (scan_done)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    // Memory port selection
    logic                        we, re;
    logic [AW-1:0]               waddr, raddr;
    logic [tmcw_pkg::CELL_W-1:0] wdata;
    logic [tmcw_pkg::CELL_W-1:0] rdata_reg;
    logic [CNTW-1:0]             cnt_prev;

    assign cnt_prev = cnt_reg - CNTW'(1);

    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = {attr, code_reg[tmcw_pkg::BYTE_W-1:0]};
        re    = 1'b0;
        raddr = AW'(addr_reg);
        priority if (cmd.scan_run)
        begin
            we    = (cnt_reg != '0);
            waddr = cnt_prev[AW-1:0];
            wdata = (cmd.scan_copy && cnt_reg <= CNTW'(MOVED)) ? rdata_reg : '0;
            re    = cmd.scan_copy && (cnt_reg < CNTW'(MOVED));
            raddr = AW'(cnt_reg + CNTW'(COLUMNS));
        end
        else if (cmd.exec)
        begin
            if (is_read)
            begin
                re = addr_ok_reg;
            end
            else if (is_bs)
            begin
                we    = 1'b1;
                waddr = pos_step[AW-1:0];
                wdata = {attr, tmcw_pkg::CHAR_SPACE};
            end
            else if (!is_left && !is_nl)
            begin
                we = 1'b1;
            end
        end
    end

    // Screen store
    logic [tmcw_pkg::CELL_W-1:0] mem [VIS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Output register
    logic out_free;
    assign out_free = !out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            cursor_pos <= tmcw_pkg::POS_W'(pos_reg);
            if (is_read)
            begin
                serial_valid <= 1'b0;
                serial_byte  <= '0;
                cell_data    <= addr_ok_reg ? rdata_reg : '0;
                last         <= 1'b1;
            end
            else
            begin
                serial_valid <= 1'b1;
                cell_data    <= '0;
                if (is_bs && cmd.emit_idx == tmcw_pkg::EMIT_SPACE)
                begin
                    serial_byte <= tmcw_pkg::CHAR_SPACE;
                end
                else if (is_bs || is_left)
                begin
                    serial_byte <= tmcw_pkg::ECHO_BS;
                end
                else
                begin
                    serial_byte <= code_reg[tmcw_pkg::BYTE_W-1:0];
                end
                last <= !is_bs || (cmd.emit_idx == tmcw_pkg::EMIT_FINAL);
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        status.is_read     = is_read;
        status.multi       = !is_read && is_bs;
        status.need_scroll = scroll;
        status.scan_done   = scan_done;
        status.out_free    = out_free;
    end

endmodule

`default_nettype wire

// File: verif/tmcw_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the text-mode console writer: watches the APB port and both item
// channels, keeps its own screen, cursor and attribute, and checks every result.
// Depends on tmcw_pkg only.

module tmcw_checker
    import tmcw_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int TEXT_ROWS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CODE_W-1:0]     char_code,
    input  logic [ADDR_W-1:0]     cell_address,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  serial_valid,
    input  logic [BYTE_W-1:0]     serial_byte,
    input  logic [POS_W-1:0]      cursor_pos,
    input  logic [CELL_W-1:0]     cell_data,
    input  logic                  last,
    output int                    fail_count,
    output int                    pending,
    output int                    item_count,
    output int                    read_count,
    output int                    result_count,
    output int                    scroll_count
);

    localparam int CELL_COUNT    = COLUMNS * (TEXT_ROWS + 1);
    localparam int VISIBLE_CELLS = COLUMNS * TEXT_ROWS;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic              serial_valid;
        logic [BYTE_W-1:0] serial_byte;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              last;
    } console_result_t;

    logic [CELL_W-1:0] screen [0:CELL_COUNT-1];
    logic [BYTE_W-1:0] attribute;
    int                cursor;
    console_result_t   due_results [$];
    int                report_count;

    // Queue one result with the current cursor
    function automatic void push_result(input logic sv, input logic [BYTE_W-1:0] sb,
                                        input logic [CELL_W-1:0] cd, input logic fin);
        console_result_t r;
        r.serial_valid = sv;
        r.serial_byte  = sb;
        r.cursor_pos   = cursor[POS_W-1:0];
        r.cell_data    = cd;
        r.last         = fin;
        due_results.push_back(r);
    endfunction

    // Apply one accepted item to the screen and queue the results it causes
    function automatic void apply_console_item(input logic [KIND_W-1:0] k,
                                               input logic [CODE_W-1:0] code,
                                               input logic [ADDR_W-1:0] addr);
        int pos;
        int i;
        logic [CELL_W-1:0] cell_val;
        if (k == KIND_READ)
        begin
            cell_val = (int'(addr) < CELL_COUNT) ? screen[addr] : '0;
            read_count++;
            push_result(1'b0, '0, cell_val, 1'b1);
            return;
        end
        pos = cursor;
        if (code == CODE_NEWLINE)
            pos += COLUMNS - pos % COLUMNS;
        else if (code == CODE_BACKSPACE || code == CODE_LEFT)
        begin
            if (pos > 0)
                pos--;
        end
        else
        begin
            if (pos < CELL_COUNT)
                screen[pos] = {attribute, code[BYTE_W-1:0]};
            pos++;
        end
        // Scroll: move rows up, rise one row, clear the tail of the last text row
        if (pos / COLUMNS >= TEXT_ROWS)
        begin
            for (i = 0; i < COLUMNS * (TEXT_ROWS - 1); i++)
                screen[i] = screen[i + COLUMNS];
            pos -= COLUMNS;
            for (i = pos; i < VISIBLE_CELLS; i++)
                screen[i] = '0;
            scroll_count++;
        end
        cursor = pos & ((1 << POS_W) - 1);
        if (code == CODE_BACKSPACE && pos < CELL_COUNT)
            screen[pos] = {attribute, CHAR_SPACE};
        if (code == CODE_BACKSPACE)
        begin
            push_result(1'b1, ECHO_BS, '0, 1'b0);
            push_result(1'b1, CHAR_SPACE, '0, 1'b0);
            push_result(1'b1, ECHO_BS, '0, 1'b1);
        end
        else if (code == CODE_LEFT)
            push_result(1'b1, ECHO_BS, '0, 1'b1);
        else
            push_result(1'b1, code[BYTE_W-1:0], '0, 1'b1);
    endfunction

    // Compare one result from the block with the oldest expectation
    function automatic void check_result();
        console_result_t want;
        console_result_t got;
        got.serial_valid = serial_valid;
        got.serial_byte  = serial_byte;
        got.cursor_pos   = cursor_pos;
        got.cell_data    = cell_data;
        got.last         = last;
        result_count++;
        if (due_results.size() == 0)
        begin
            fail_count++;
            if (report_count < MAX_REPORTS)
                $display("%0t: result with no item outstanding: sv=%0d byte=%0d pos=%0d cell=%h last=%0d",
                         $realtime, got.serial_valid, got.serial_byte, got.cursor_pos,
                         got.cell_data, got.last);
            report_count++;
            return;
        end
        want = due_results.pop_front();
        if (got !== want)
        begin
            fail_count++;
            if (report_count < MAX_REPORTS)
            begin
                $display("%0t: result mismatch", $realtime);
                $display("    expected sv=%0d byte=%0d pos=%0d cell=%h last=%0d",
                         want.serial_valid, want.serial_byte, want.cursor_pos,
                         want.cell_data, want.last);
                $display("    actual   sv=%0d byte=%0d pos=%0d cell=%h last=%0d",
                         got.serial_valid, got.serial_byte, got.cursor_pos,
                         got.cell_data, got.last);
            end
            report_count++;
        end
    endfunction

    // Watch the handshakes; results leave before the item of the same edge enters
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen[i] = '0;
            attribute    = ATTR_RESET;
            cursor       = 0;
            due_results.delete();
            fail_count   = 0;
            report_count = 0;
            item_count   = 0;
            read_count   = 0;
            result_count = 0;
            scroll_count = 0;
            pending      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_ATTR, 2'b00})
                attribute = pwdata[BYTE_W-1:0];
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
            begin
                item_count++;
                apply_console_item(kind, char_code, cell_address);
            end
            pending = due_results.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the console writer testbench: clock, reset, APB writes and item stimulus.
// Depends on tmcw_pkg, text_mode_console_writer_unit and tmcw_checker.

module tb;
    import tmcw_pkg::*;

    localparam int COLUMNS   = 80;
    localparam int TEXT_ROWS = 24;
    localparam int ADDR_MAX  = (1 << ADDR_W) - 1;
    localparam int CODE_MAX  = (1 << CODE_W) - 1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind;
    logic [CODE_W-1:0]     char_code;
    logic [ADDR_W-1:0]     cell_address;
    logic                  out_valid;
    logic                  out_ready;
    logic                  serial_valid;
    logic [BYTE_W-1:0]     serial_byte;
    logic [POS_W-1:0]      cursor_pos;
    logic [CELL_W-1:0]     cell_data;
    logic                  last;

    int fail_count;
    int pending;
    int item_count;
    int read_count;
    int result_count;
    int scroll_count;

    int   items_sent;
    logic quiet;
    int   squeeze_count;
    int   squeezes_done;

    text_mode_console_writer_unit #(
        .COLUMNS   (COLUMNS),
        .TEXT_ROWS (TEXT_ROWS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_valid (serial_valid),
        .serial_byte  (serial_byte),
        .cursor_pos   (cursor_pos),
        .cell_data    (cell_data),
        .last         (last)
    );

    tmcw_checker #(
        .COLUMNS   (COLUMNS),
        .TEXT_ROWS (TEXT_ROWS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .char_code    (char_code),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_valid (serial_valid),
        .serial_byte  (serial_byte),
        .cursor_pos   (cursor_pos),
        .cell_data    (cell_data),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .item_count   (item_count),
        .read_count   (read_count),
        .result_count (result_count),
        .scroll_count (scroll_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung run
    initial
    begin
        #50000000;
        $display("text_mode_console_writer_unit test failed");
        $finish;
    end

    // Accept results, idling at random; hold off for a long stretch on request
    initial
    begin
        out_ready     = 1'b0;
        squeezes_done = 0;
        forever
        begin
            @(posedge clk);
            if (squeezes_done != squeeze_count)
            begin
                squeezes_done++;
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
                out_ready <= rst_n && (quiet || $urandom_range(0, 99) >= 34);
        end
    end

    // Offer one item and hold it until accepted; valid stays high on return
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [CODE_W-1:0] c,
                             input logic [ADDR_W-1:0] a);
        while (!quiet && $urandom_range(0, 99) < 34)
        begin
            in_valid     <= 1'b0;
            kind         <= KIND_W'($urandom_range(0, 1));
            char_code    <= CODE_W'($urandom_range(0, CODE_MAX));
            cell_address <= ADDR_W'($urandom_range(0, ADDR_MAX));
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        char_code    <= c;
        cell_address <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the attribute register; upper data bits carry noise
    task automatic write_attribute(input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ATTR, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_FF00) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic built from typing runs, newline bursts, read sweeps and noise
    task automatic run_random(input int n);
        int stop;
        int mode;
        int len;
        int pick;
        int base;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 55)
            begin
                len = $urandom_range(5, 40);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        send_item(KIND_PUT, CODE_BACKSPACE,
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    else if (pick < 14)
                        send_item(KIND_PUT, CODE_LEFT,
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    else if (pick < 22)
                        send_item(KIND_PUT, CODE_NEWLINE,
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    else if (pick < 27)
                        send_item(KIND_READ, CODE_W'($urandom_range(0, CODE_MAX)),
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    else if (pick < 37)
                        send_item(KIND_PUT, CODE_W'($urandom_range(0, CODE_MAX)),
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                    else
                        send_item(KIND_PUT, CODE_W'($urandom_range(32, 126)),
                                  ADDR_W'($urandom_range(0, ADDR_MAX)));
                end
            end
            else if (mode < 70)
            begin
                len = $urandom_range(3, 26);
                for (int i = 0; i < len; i++)
                    send_item(KIND_PUT, CODE_NEWLINE, ADDR_W'($urandom_range(0, ADDR_MAX)));
            end
            else if (mode < 85)
            begin
                len  = $urandom_range(2, 8);
                base = $urandom_range(0, ADDR_MAX);
                for (int i = 0; i < len; i++)
                    send_item(KIND_READ, CODE_W'($urandom_range(0, CODE_MAX)),
                              ADDR_W'((base + i) & ADDR_MAX));
            end
            else
                send_item(KIND_W'($urandom_range(0, 1)), CODE_W'($urandom_range(0, CODE_MAX)),
                          ADDR_W'($urandom_range(0, ADDR_MAX)));
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        kind          = KIND_PUT;
        char_code     = '0;
        cell_address  = '0;
        items_sent    = 0;
        quiet         = 1'b0;
        squeeze_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset attribute, edges at cursor 0, code extremes, reads past the store
        send_item(KIND_READ, 9'd0, 11'd0);
        send_item(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_item(KIND_PUT, CODE_LEFT, 11'd0);
        send_item(KIND_READ, 9'd0, 11'd0);
        send_item(KIND_PUT, 9'd0, 11'd0);
        send_item(KIND_PUT, 9'd255, 11'd0);
        send_item(KIND_PUT, 9'd257, 11'd0);
        send_item(KIND_PUT, 9'd511, 11'd2047);
        send_item(KIND_PUT, 9'd65, 11'd0);
        send_item(KIND_PUT, CODE_LEFT, 11'd0);
        send_item(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_item(KIND_READ, 9'd511, 11'd3);
        send_item(KIND_READ, 9'd0, 11'd4);
        send_item(KIND_PUT, CODE_NEWLINE, 11'd2047);
        send_item(KIND_PUT, CODE_BACKSPACE, 11'd0);
        send_item(KIND_PUT, 9'd122, 11'd0);
        send_item(KIND_PUT, CODE_NEWLINE, 11'd0);
        send_item(KIND_READ, 9'd0, 11'd79);
        send_item(KIND_READ, 9'd0, 11'd1919);
        send_item(KIND_READ, 9'd0, 11'd1920);
        send_item(KIND_READ, 9'd0, 11'd1999);
        send_item(KIND_READ, 9'd0, 11'd2000);
        send_item(KIND_READ, 9'd0, 11'd2047);
        drain();

        // Top attribute value
        write_attribute(8'hFF);
        run_random(150);
        drain();

        // Bottom attribute value, with a stretch where neither side idles
        write_attribute(8'h00);
        quiet = 1'b1;
        run_random(80);
        quiet = 1'b0;
        run_random(70);
        drain();

        // Random attribute value; stall the receiver while items keep coming
        write_attribute(BYTE_W'($urandom_range(1, 254)));
        run_random(40);
        squeeze_count++;
        run_random(110);
        drain();

        repeat (50) @(posedge clk);
        $display("Covered %0d items (%0d reads) with %0d results and %0d scrolls",
                 item_count, read_count, result_count, scroll_count);
        $display("across the reset, top, bottom and a random attribute value");
        if (fail_count == 0 && pending == 0)
            $display("text_mode_console_writer_unit test passed");
        else
            $display("text_mode_console_writer_unit test failed");
        $finish;
    end

endmodule
